FILE: rtl/c2c_pkg.sv
// Shared types and constants for the sparse coordinate-to-column converter.
package c2c_pkg;
	localparam int MaxDim = 1024;
	localparam int DimW   = 11;
	localparam int RowW   = 10;
	localparam int ValW   = 64;

	localparam logic [1:0] ReqLoad  = 2'd0;
	localparam logic [1:0] ReqFetch = 2'd1;
	localparam logic [1:0] ReqClear = 2'd2;

	localparam logic [1:0] KindPtr   = 2'd0;
	localparam logic [1:0] KindEntry = 2'd1;
	localparam logic [1:0] KindEmpty = 2'd2;
	localparam logic [1:0] KindShape = 2'd3;

	localparam logic [1:0] CfgRows  = 2'd0;
	localparam logic [1:0] CfgCols  = 2'd1;
	localparam logic [1:0] CfgLower = 2'd2;

	typedef struct packed {
		logic [ValW-1:0] value;
		logic [RowW-1:0] col;
		logic [RowW-1:0] row;
	} entry_t;

	function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
		if (v == '0) begin
			return DimW'(1);
		end else if (v > DimW'(MaxDim)) begin
			return DimW'(MaxDim);
		end
		return v;
	endfunction
endpackage

FILE: rtl/c2c_ram.sv
// Simple dual-port synchronous RAM with registered read data.
module c2c_ram #(
	parameter int W  = 8,
	parameter int D  = 16,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/coo_to_csc_converter.sv
// Top level: entry store, counting-sort grouping pass and packed-column readout.
//  channel | dir | handshake       | payload
//  s_*     | in  | tvalid/tready   | tuser=req_type, tdata=row,col,value
//  m_*     | out | tvalid/tready   | tuser=kind, tdata=ptr,row,value,overflow; tlast=last
//  cfg_*   | in  | cfg_we          | cfg_index, cfg_wdata
// Load and clear are done in the idle state. A fetch that needs no grouping passes
// StOrd and StOpt for a pointer word and StOrd, StOe1 and StOe2 for an entry word,
// bounded by the registered memory reads. The first fetch of a readout runs a grouping
// pass over the count memory. Reset clears only control state; no clearing pass.
// Input is held off while a result waits in the output register.
module coo_to_csc_converter #(
	parameter int MAX_ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // row_index[9:0], col_index[19:10], value_bits[83:20]
	input  logic [1:0]  s_tuser,   // req_type[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // column_pointer[10:0], out_row[20:11], out_value[84:21], overflow[85]
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_wdata
);
	localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int CUW = $clog2(c2c_pkg::MaxDim + MAX_ENTRIES + 2);
	localparam int PW  = c2c_pkg::DimW;
	localparam int EW  = $bits(c2c_pkg::entry_t);

	localparam logic [3:0] StIdle = 4'd0;
	localparam logic [3:0] StClr  = 4'd1;
	localparam logic [3:0] StHrd  = 4'd2;
	localparam logic [3:0] StHcn  = 4'd3;
	localparam logic [3:0] StHwr  = 4'd4;
	localparam logic [3:0] StPrd  = 4'd5;
	localparam logic [3:0] StPwr  = 4'd6;
	localparam logic [3:0] StPend = 4'd7;
	localparam logic [3:0] StSrd  = 4'd8;
	localparam logic [3:0] StScn  = 4'd9;
	localparam logic [3:0] StSwr  = 4'd10;
	localparam logic [3:0] StOrd  = 4'd11;
	localparam logic [3:0] StOpt  = 4'd12;
	localparam logic [3:0] StOe1  = 4'd13;
	localparam logic [3:0] StOe2  = 4'd14;

	logic [3:0]      state_q;
	logic [10:0]     nrows_q, ncols_q;
	logic            lower_q;
	logic [CW-1:0]   count_q;
	logic            ovf_q;
	logic [CUW-1:0]  cur_q;
	logic [CW-1:0]   kept_q;
	logic [CW-1:0]   acc_q;
	logic [PW-1:0]   col_q;
	logic [CW-1:0]   ei_q;
	logic            keep_q;
	logic [PW-1:0]   kcol_q;

	logic            mv_q, ml_q, mo_q;
	logic [1:0]      mk_q;
	logic [PW-1:0]   mp_q;
	logic [9:0]      mr_q;
	logic [63:0]     mval_q;

	logic [PW-1:0]   nr, nc;
	logic            acc_in;
	c2c_pkg::entry_t s_ent, e_rd;
	logic [EW-1:0]   e_rdata;
	logic            e_we;
	logic [EAW-1:0]  e_raddr;
	logic            c_we;
	logic [PW-1:0]   c_waddr, c_raddr;
	logic [CW-1:0]   c_wdata, c_rdata;
	logic            st_we;
	logic [PW-1:0]   st_waddr;
	logic [CW-1:0]   st_rdata;
	logic            o_we;
	logic [EAW-1:0]  o_raddr;
	logic [EAW-1:0]  o_rdata;
	logic            e_keep;
	logic            is_last;
	logic [CUW-1:0]  k_idx;

	assign nr       = c2c_pkg::clamp_dim(nrows_q);
	assign nc       = c2c_pkg::clamp_dim(ncols_q);
	assign s_tready = (state_q == StIdle) && !mv_q;
	assign acc_in   = s_tvalid && s_tready;
	assign s_ent    = s_tdata[EW-1:0];
	assign e_rd     = e_rdata;
	assign e_keep   = ({1'b0, e_rd.col} < nc) && (!lower_q || (e_rd.row >= e_rd.col));
	assign is_last  = cur_q >= (CUW'(nc) + CUW'(kept_q));
	assign k_idx    = cur_q - CUW'(nc) - CUW'(1);
	assign e_we     = acc_in && (s_tuser == c2c_pkg::ReqLoad) && (count_q < CW'(MAX_ENTRIES));

	always_comb begin
		e_raddr = ei_q[EAW-1:0];
		if (state_q == StOe1) begin
			e_raddr = o_rdata;
		end
	end

	always_comb begin
		c_we    = 1'b0;
		c_waddr = col_q;
		c_wdata = '0;
		c_raddr = col_q;
		case (state_q)
			StClr: begin
				c_we = 1'b1;
			end
			StHcn, StScn: begin
				c_raddr = {1'b0, e_rd.col};
			end
			StHwr, StSwr: begin
				c_we    = keep_q;
				c_waddr = kcol_q;
				c_wdata = c_rdata + CW'(1);
			end
			StPwr: begin
				c_we    = 1'b1;
				c_wdata = acc_q;
			end
			default: begin
			end
		endcase
	end

	assign st_we    = (state_q == StPwr) || (state_q == StPend);
	assign st_waddr = (state_q == StPend) ? nc : col_q;
	assign o_we     = (state_q == StSwr) && keep_q;
	assign o_raddr  = k_idx[EAW-1:0];

	c2c_ram #(.W(EW), .D(MAX_ENTRIES), .AW(EAW)) u_ent (
		.clk(clk), .we(e_we), .waddr(count_q[EAW-1:0]), .wdata(s_ent),
		.raddr(e_raddr), .rdata(e_rdata)
	);
	c2c_ram #(.W(CW), .D(c2c_pkg::MaxDim + 1), .AW(PW)) u_cnt (
		.clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
		.raddr(c_raddr), .rdata(c_rdata)
	);
	c2c_ram #(.W(CW), .D(c2c_pkg::MaxDim + 1), .AW(PW)) u_start (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(acc_q),
		.raddr(cur_q[PW-1:0]), .rdata(st_rdata)
	);
	c2c_ram #(.W(EAW), .D(MAX_ENTRIES), .AW(EAW)) u_order (
		.clk(clk), .we(o_we), .waddr(c_rdata[EAW-1:0]), .wdata(ei_q[EAW-1:0]),
		.raddr(o_raddr), .rdata(o_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == StHcn || state_q == StScn) begin
			keep_q <= e_keep;
			kcol_q <= {1'b0, e_rd.col};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			nrows_q <= 11'd1024;
			ncols_q <= 11'd1024;
			lower_q <= 1'b0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			cur_q   <= '0;
			kept_q  <= '0;
			acc_q   <= '0;
			col_q   <= '0;
			ei_q    <= '0;
			mv_q    <= 1'b0;
			ml_q    <= 1'b0;
			mo_q    <= 1'b0;
			mk_q    <= c2c_pkg::KindPtr;
			mp_q    <= '0;
			mr_q    <= '0;
			mval_q  <= '0;
		end else begin
			if (mv_q && m_tready) begin
				mv_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					c2c_pkg::CfgRows: begin
						nrows_q <= cfg_wdata;
						cur_q   <= '0;
					end
					c2c_pkg::CfgCols: begin
						ncols_q <= cfg_wdata;
						cur_q   <= '0;
					end
					c2c_pkg::CfgLower: begin
						lower_q <= cfg_wdata[0];
						cur_q   <= '0;
					end
					default: begin
					end
				endcase
			end
			case (state_q)
				StIdle: begin
					if (acc_in) begin
						case (s_tuser)
							c2c_pkg::ReqLoad: begin
								if (count_q < CW'(MAX_ENTRIES)) begin
									count_q <= count_q + CW'(1);
								end else begin
									ovf_q <= 1'b1;
								end
								cur_q <= '0;
							end
							c2c_pkg::ReqClear: begin
								count_q <= '0;
								ovf_q   <= 1'b0;
								cur_q   <= '0;
								kept_q  <= '0;
							end
							c2c_pkg::ReqFetch: begin
								if ((lower_q && (nr != nc)) || (count_q == '0)) begin
									mv_q   <= 1'b1;
									mk_q   <= (lower_q && (nr != nc)) ? c2c_pkg::KindShape
									                                  : c2c_pkg::KindEmpty;
									ml_q   <= 1'b1;
									mo_q   <= ovf_q;
									mp_q   <= '0;
									mr_q   <= '0;
									mval_q <= '0;
									cur_q  <= '0;
								end else if (cur_q == '0) begin
									col_q   <= '0;
									state_q <= StClr;
								end else begin
									state_q <= StOrd;
								end
							end
							default: begin
							end
						endcase
					end
				end
				StClr: begin
					if (col_q == nc - PW'(1)) begin
						ei_q    <= '0;
						state_q <= StHrd;
					end else begin
						col_q <= col_q + PW'(1);
					end
				end
				StHrd: begin
					if (ei_q == count_q) begin
						col_q   <= '0;
						acc_q   <= '0;
						state_q <= StPrd;
					end else begin
						state_q <= StHcn;
					end
				end
				StHcn: begin
					state_q <= StHwr;
				end
				StHwr: begin
					ei_q    <= ei_q + CW'(1);
					state_q <= StHrd;
				end
				StPrd: begin
					state_q <= StPwr;
				end
				StPwr: begin
					acc_q <= acc_q + c_rdata;
					if (col_q == nc - PW'(1)) begin
						state_q <= StPend;
					end else begin
						col_q   <= col_q + PW'(1);
						state_q <= StPrd;
					end
				end
				StPend: begin
					kept_q  <= acc_q;
					ei_q    <= '0;
					state_q <= StSrd;
				end
				StSrd: begin
					state_q <= (ei_q == count_q) ? StOrd : StScn;
				end
				StScn: begin
					state_q <= StSwr;
				end
				StSwr: begin
					ei_q    <= ei_q + CW'(1);
					state_q <= StSrd;
				end
				StOrd: begin
					state_q <= (cur_q <= CUW'(nc)) ? StOpt : StOe1;
				end
				StOpt, StOe2: begin
					mv_q   <= 1'b1;
					mo_q   <= ovf_q;
					ml_q   <= is_last;
					if (state_q == StOpt) begin
						mk_q   <= c2c_pkg::KindPtr;
						mp_q   <= PW'(st_rdata);
						mr_q   <= '0;
						mval_q <= '0;
					end else begin
						mk_q   <= c2c_pkg::KindEntry;
						mp_q   <= '0;
						mr_q   <= e_rd.row;
						mval_q <= e_rd.value;
					end
					cur_q   <= is_last ? '0 : cur_q + CUW'(1);
					state_q <= StIdle;
				end
				StOe1: begin
					state_q <= StOe2;
				end
				default: begin
					state_q <= StIdle;
				end
			endcase
		end
	end

	assign m_tvalid = mv_q;
	assign m_tuser  = mk_q;
	assign m_tlast  = ml_q;
	assign m_tdata  = {2'b00, mo_q, mval_q, mr_q, mp_q};
endmodule

FILE: rtl/c2c_checker.sv
// Port-level checker for the converter, bound to the top level.
module c2c_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [87:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == c2c_pkg::KindEmpty || m_tuser == c2c_pkg::KindShape)
		|-> m_tlast)
		else $error("error word without last");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input ready while result pending");

	a_entry_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == c2c_pkg::KindEntry |-> m_tdata[10:0] == 11'd0)
		else $error("entry word carries pointer");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled item changed");
endmodule

bind coo_to_csc_converter c2c_checker u_c2c_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
